### hw/rtl/arl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arl_pkg
// shared widths, constants, register indexes and controller command bundle
// for the auto-ranging audio level meter
// ----------------------------------------------------------------------------
package arl_pkg;

    // sample and range tracking widths
    localparam int SAMPLE_W = 10;
    localparam int POS_W    = SAMPLE_W + 2;  // signed floor / ceiling / span
    localparam int MID_W    = POS_W - 1;     // signed half span
    localparam int DIST_W   = SAMPLE_W + 1;  // distance from midpoint
    localparam int CORR_W   = 16;
    localparam int NOISE_W  = 21;

    // result widths
    localparam int LEVEL_W  = 9;
    localparam int VOLUME_W = 7;

    // configuration register widths
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;
    localparam int PERIOD_W     = 15;
    localparam int LIMIT_W      = 20;
    localparam int THRESH_W     = 9;

    // shared divider: quotient of LEVEL_W bits, divisor is the positive midpoint
    localparam int DIV_Q_W = LEVEL_W;
    localparam int DIV_D_W = MID_W - 1;
    localparam int DIV_N_W = DIV_D_W + DIV_Q_W;
    localparam int STEP_W  = $clog2(DIV_Q_W + 1);

    localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = LEVEL_W'(511);
    localparam logic [VOLUME_W-1:0] VOLUME_MAX = VOLUME_W'(100);
    localparam logic signed [POS_W-1:0] CEIL_OFFSET  = POS_W'(10);
    localparam logic signed [POS_W-1:0] FLOOR_OFFSET = POS_W'(5);
    localparam logic [NOISE_W-1:0] NOISE_CNT_MAX = {NOISE_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LOUD_LIMIT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_LIMIT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LOUD_THR    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_THR   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_LOUD_CLR    = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_CLR   = CFG_IDX_W'(6);

    // reset values of the registers
    localparam logic [PERIOD_W-1:0] CORR_PERIOD_RST = PERIOD_W'(1000);
    localparam logic [LIMIT_W-1:0]  LIMIT_RST       = LIMIT_W'(10000);
    localparam logic [THRESH_W-1:0] LOUD_THR_RST    = THRESH_W'(384);
    localparam logic [THRESH_W-1:0] QUIET_THR_RST   = THRESH_W'(128);
    localparam logic [THRESH_W-1:0] LOUD_CLR_RST    = THRESH_W'(0);
    localparam logic [THRESH_W-1:0] QUIET_CLR_RST   = THRESH_W'(511);

    // controller to datapath commands
    typedef struct packed {
        logic load_sample;   // capture the accepted sample
        logic update_range;  // correction, floor / ceiling tracking, re-center
        logic calc_center;   // span, midpoint, distance
        logic div_load;      // load divider operands
        logic div_step;      // one divider iteration
        logic div_sel_vol;   // divider works on volume rather than level
        logic finish_level;  // take level, update noise counters
        logic load_out;      // fill output register
    } arl_cmd_t;

endpackage

### hw/rtl/arl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arl_div
// restoring divider, one quotient bit per step, dividend below divisor << DIV_Q_W
// ----------------------------------------------------------------------------
module arl_div (
    input  logic                        aclk,
    input  logic                        load,
    input  logic                        step,
    input  logic [arl_pkg::DIV_N_W-1:0] dividend,
    input  logic [arl_pkg::DIV_D_W-1:0] divisor,
    output logic [arl_pkg::DIV_Q_W-1:0] quotient
);
    import arl_pkg::*;

    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_Q_W-1:0] shift_reg;
    logic [DIV_Q_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] divisor_reg;

    logic [DIV_D_W:0] trial;
    logic             fits;

    assign trial = {rem_reg, shift_reg[DIV_Q_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg     <= dividend[DIV_N_W-1:DIV_Q_W];
            shift_reg   <= dividend[DIV_Q_W-1:0];
            divisor_reg <= divisor;
            quo_reg     <= '0;
        end else if (step) begin
            rem_reg   <= fits ? DIV_D_W'(trial - {1'b0, divisor_reg}) : DIV_D_W'(trial);
            shift_reg <= {shift_reg[DIV_Q_W-2:0], 1'b0};
            quo_reg   <= {quo_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;

endmodule

### hw/rtl/arl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arl_ctrl
// sequencer for one sample: range update, center, two divides, result handoff
// ----------------------------------------------------------------------------
module arl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output arl_pkg::arl_cmd_t cmd
);
    import arl_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_RANGE   = 7'b0000010,
        ST_CENTER  = 7'b0000100,
        ST_DIV_LVL = 7'b0001000,
        ST_LEVEL   = 7'b0010000,
        ST_DIV_VOL = 7'b0100000,
        ST_DONE    = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;
    logic              div_last;

    assign out_free = !m_valid_reg || m_ready;
    assign div_last = step_reg == STEP_W'(DIV_Q_W);

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg) inside
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_sample = 1'b1;
                    state_next      = ST_RANGE;
                end
            end
            ST_RANGE: begin
                cmd.update_range = 1'b1;
                state_next       = ST_CENTER;
            end
            ST_CENTER: begin
                cmd.calc_center = 1'b1;
                step_next       = '0;
                state_next      = ST_DIV_LVL;
            end
            ST_DIV_LVL, ST_DIV_VOL: begin
                cmd.div_sel_vol = state_reg == ST_DIV_VOL;
                cmd.div_load    = step_reg == '0;
                cmd.div_step    = step_reg != '0;
                step_next       = step_reg + 1'b1;
                if (div_last) begin
                    step_next  = '0;
                    state_next = (state_reg == ST_DIV_VOL) ? ST_DONE : ST_LEVEL;
                end
            end
            ST_LEVEL: begin
                cmd.finish_level = 1'b1;
                state_next       = ST_DIV_VOL;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule

### hw/rtl/arl_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arl_datapath
// configuration registers, range tracking state, level / volume arithmetic
// ----------------------------------------------------------------------------
module arl_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  arl_pkg::arl_cmd_t             cmd,
    input  logic                          cfg_we,
    input  logic [arl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [arl_pkg::SAMPLE_W-1:0]   s_sample,
    output logic [arl_pkg::LEVEL_W-1:0]    m_level,
    output logic [arl_pkg::VOLUME_W-1:0]   m_volume,
    output logic signed [arl_pkg::POS_W-1:0] m_span,
    output logic                          m_recentred
);
    import arl_pkg::*;

    // configuration
    logic [PERIOD_W-1:0] corr_period_reg;
    logic [LIMIT_W-1:0]  loud_limit_reg, quiet_limit_reg;
    logic [THRESH_W-1:0] loud_thr_reg, quiet_thr_reg, loud_clr_reg, quiet_clr_reg;

    // tracking state
    logic [SAMPLE_W-1:0]     prev_reg;
    logic signed [POS_W-1:0] floor_reg, ceil_reg;
    logic [CORR_W-1:0]       corr_cnt_reg;
    logic [NOISE_W-1:0]      loud_cnt_reg, quiet_cnt_reg;

    // per-transaction working registers
    logic [SAMPLE_W-1:0]     sample_reg;
    logic                    recentred_reg;
    logic signed [POS_W-1:0] span_reg;
    logic signed [MID_W-1:0] mid_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic                    mid_neg_reg, mid_zero_reg, sat_reg;
    logic [LEVEL_W-1:0]      level_reg;

    // output register
    logic [LEVEL_W-1:0]      out_level_reg;
    logic [VOLUME_W-1:0]     out_volume_reg;
    logic signed [POS_W-1:0] out_span_reg;
    logic                    out_recentred_reg;

    // range update
    logic signed [POS_W-1:0] sample_pos, prev_pos, half_pos;
    logic signed [POS_W-1:0] floor_next, ceil_next;
    logic [CORR_W-1:0]       corr_inc, corr_next;
    logic                    recentre;

    assign sample_pos = POS_W'(sample_reg);
    assign prev_pos   = POS_W'(prev_reg);
    assign half_pos   = POS_W'(sample_reg >> 1);
    assign corr_inc   = corr_cnt_reg + 1'b1;
    assign recentre   = (loud_cnt_reg > NOISE_W'(loud_limit_reg))
                     || (quiet_cnt_reg > NOISE_W'(quiet_limit_reg));

    always_comb begin
        floor_next = floor_reg;
        ceil_next  = ceil_reg;
        corr_next  = corr_inc;
        if (corr_inc > CORR_W'(corr_period_reg)) begin
            floor_next = floor_reg + POS_W'(1);
            ceil_next  = ceil_reg - POS_W'(1);
            corr_next  = '0;
        end
        if (prev_pos < floor_next) begin
            floor_next = prev_pos;
        end
        if (sample_pos > ceil_next) begin
            ceil_next = sample_pos;
        end
        if (recentre) begin
            ceil_next  = half_pos + CEIL_OFFSET;
            floor_next = half_pos - FLOOR_OFFSET;
        end
    end

    // span, midpoint (truncated toward zero) and distance
    logic signed [POS_W-1:0] span_c, span_adj;
    logic signed [MID_W-1:0] mid_c;
    logic signed [POS_W:0]   diff_c, diff_abs;
    logic [DIST_W-1:0]       dist_c;

    assign span_c   = ceil_reg - floor_reg;
    assign span_adj = span_c + POS_W'(span_c[POS_W-1]);
    assign mid_c    = MID_W'(span_adj >>> 1);
    assign diff_c   = (POS_W+1)'(sample_pos) - (POS_W+1)'(floor_reg) - (POS_W+1)'(mid_c);
    assign diff_abs = diff_c[POS_W] ? -diff_c : diff_c;
    assign dist_c   = DIST_W'(diff_abs);

    // shared divider
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_Q_W-1:0] div_quo;

    assign div_dividend = cmd.div_sel_vol
                        ? DIV_N_W'(level_reg) * DIV_N_W'(VOLUME_MAX)
                        : DIV_N_W'(dist_reg) * DIV_N_W'(LEVEL_MAX);

    arl_div u_div (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (div_dividend),
        .divisor  (mid_reg[DIV_D_W-1:0]),
        .quotient (div_quo)
    );

    // level with the midpoint special cases
    logic [LEVEL_W-1:0] level_c;
    always_comb begin
        if (mid_neg_reg) begin
            level_c = '0;
        end else if (mid_zero_reg) begin
            level_c = (dist_reg != '0) ? LEVEL_MAX : '0;
        end else if (sat_reg) begin
            level_c = LEVEL_MAX;
        end else begin
            level_c = div_quo;
        end
    end

    // noise counters after this level
    logic [NOISE_W-1:0] loud_upd, quiet_upd;
    always_comb begin
        loud_upd  = loud_cnt_reg;
        quiet_upd = quiet_cnt_reg;
        if (level_c > loud_thr_reg && loud_cnt_reg != NOISE_CNT_MAX) begin
            loud_upd = loud_cnt_reg + 1'b1;
        end
        if (level_c < quiet_thr_reg && quiet_cnt_reg != NOISE_CNT_MAX) begin
            quiet_upd = quiet_cnt_reg + 1'b1;
        end
        if (level_c <= loud_clr_reg) begin
            loud_upd = '0;
        end
        if (level_c >= quiet_clr_reg) begin
            quiet_upd = '0;
        end
    end

    // volume with the same special cases
    logic [VOLUME_W-1:0] volume_c;
    always_comb begin
        if (mid_neg_reg) begin
            volume_c = '0;
        end else if (mid_zero_reg) begin
            volume_c = (level_reg != '0) ? VOLUME_MAX : '0;
        end else if ({1'b0, level_reg} >= mid_reg[DIV_D_W-1:0]) begin
            volume_c = VOLUME_MAX;
        end else begin
            volume_c = VOLUME_W'(div_quo);
        end
    end

    // control state: configuration and tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corr_period_reg <= CORR_PERIOD_RST;
            loud_limit_reg  <= LIMIT_RST;
            quiet_limit_reg <= LIMIT_RST;
            loud_thr_reg    <= LOUD_THR_RST;
            quiet_thr_reg   <= QUIET_THR_RST;
            loud_clr_reg    <= LOUD_CLR_RST;
            quiet_clr_reg   <= QUIET_CLR_RST;
            prev_reg        <= '0;
            floor_reg       <= '0;
            ceil_reg        <= '0;
            corr_cnt_reg    <= '0;
            loud_cnt_reg    <= '0;
            quiet_cnt_reg   <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_CORR_PERIOD: corr_period_reg <= cfg_data[PERIOD_W-1:0];
                    CFG_LOUD_LIMIT:  loud_limit_reg  <= cfg_data[LIMIT_W-1:0];
                    CFG_QUIET_LIMIT: quiet_limit_reg <= cfg_data[LIMIT_W-1:0];
                    CFG_LOUD_THR:    loud_thr_reg    <= cfg_data[THRESH_W-1:0];
                    CFG_QUIET_THR:   quiet_thr_reg   <= cfg_data[THRESH_W-1:0];
                    CFG_LOUD_CLR:    loud_clr_reg    <= cfg_data[THRESH_W-1:0];
                    CFG_QUIET_CLR:   quiet_clr_reg   <= cfg_data[THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.update_range) begin
                prev_reg     <= sample_reg;
                floor_reg    <= floor_next;
                ceil_reg     <= ceil_next;
                corr_cnt_reg <= corr_next;
                if (recentre) begin
                    loud_cnt_reg  <= '0;
                    quiet_cnt_reg <= '0;
                end
            end
            if (cmd.finish_level) begin
                loud_cnt_reg  <= loud_upd;
                quiet_cnt_reg <= quiet_upd;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            sample_reg <= s_sample;
        end
        if (cmd.update_range) begin
            recentred_reg <= recentre;
        end
        if (cmd.calc_center) begin
            span_reg     <= span_c;
            mid_reg      <= mid_c;
            dist_reg     <= dist_c;
            mid_neg_reg  <= mid_c[MID_W-1];
            mid_zero_reg <= mid_c == '0;
            sat_reg      <= dist_c >= DIST_W'(mid_c[DIV_D_W-1:0]);
        end
        if (cmd.finish_level) begin
            level_reg <= level_c;
        end
        if (cmd.load_out) begin
            out_level_reg     <= level_reg;
            out_volume_reg    <= volume_c;
            out_span_reg      <= span_reg;
            out_recentred_reg <= recentred_reg;
        end
    end

    assign m_level     = out_level_reg;
    assign m_volume    = out_volume_reg;
    assign m_span      = out_span_reg;
    assign m_recentred = out_recentred_reg;

endmodule

### hw/rtl/auto_ranging_audio_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_ranging_audio_level
// audio level meter that tracks its own floor and ceiling and reports level,
// volume, span and a re-center flag for every converter sample
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one 10-bit unsigned sample per transaction (s_valid / s_ready)
//   m_ channel: one result per sample: level 0..511, volume 0..100, signed
//               12-bit span and the recentred flag (m_valid / m_ready)
//   cfg channel: register index and data, always ready; write only while idle
// sequencing: one sample at a time; the sequencer runs the range
//   update, the center calculation and two 9-step divides on one shared
//   restoring divider (1 load + 9 steps each)
// stall: the finished result waits in the output register; the next sample
//   is taken and worked on meanwhile, and the sequencer holds only at the
//   final handoff while the previous result is still not taken
// reset: synchronous active-low aresetn clears the sequencer, the tracking
//   state (floor, ceiling, previous sample, counters) and loads the register
//   defaults; no clearing pass is needed
// ----------------------------------------------------------------------------
module auto_ranging_audio_level (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [arl_pkg::SAMPLE_W-1:0]   s_sample,
    // result output
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [arl_pkg::LEVEL_W-1:0]    m_level,
    output logic [arl_pkg::VOLUME_W-1:0]   m_volume,
    output logic signed [arl_pkg::POS_W-1:0] m_span,
    output logic                          m_recentred,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [arl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arl_pkg::CFG_DATA_W-1:0] cfg_data
);
    import arl_pkg::*;

    arl_cmd_t cmd;

    // register writes go straight into the configuration registers, never back-pressured
    assign cfg_ready = 1'b1;

    // sequencer: owns the sample and result handshakes and the divider step count
    arl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // datapath: registers, tracking state, arithmetic and output register
    arl_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_sample    (s_sample),
        .m_level     (m_level),
        .m_volume    (m_volume),
        .m_span      (m_span),
        .m_recentred (m_recentred)
    );

    // output register is only refilled once the held result is gone
    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("result register refilled while a result was pending");

    // one sample at a time: ready drops right after a transaction
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second sample accepted while one is in progress");

    // a result cannot appear the cycle after its sample was taken
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result valid too early after input transaction");

    // volume is clamped
    a_volume_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_volume <= VOLUME_MAX))
        else $error("volume out of range");

endmodule

### verif/auto_ranging_audio_level_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_ranging_audio_level_test
// self-checking bench for the auto-ranging audio level meter: a scoreboard
// class tracks floor, ceiling, correction and noise counters of its own and
// predicts level, volume, span and the re-center flag for every sample; the
// run goes through directed edge cases and random waveforms under several
// register settings and handshake idling patterns
// ----------------------------------------------------------------------------
module auto_ranging_audio_level_test;

    import arl_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 7;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int PRESSURE_PHASE  = 4;
    // receiver hold-off, far longer than the block can buffer
    localparam int HOLD_CYCLES     = 400;
    // leave a margin after the last reading before touching registers
    localparam int DRAIN_CYCLES    = 40;
    // cycles without any transaction before the run is declared hung;
    // the longest legal quiet stretch is the receiver hold-off
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int MAX_REPORTS     = 10;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;

    // index past the register list, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = CFG_IDX_W'(7);

    typedef struct {
        logic [LEVEL_W-1:0]  level;
        logic [VOLUME_W-1:0] volume;
        logic [POS_W-1:0]    span;
        logic                recentred;
    } meter_reading_t;

    // ------------------------------------------------------------------------
    // scoreboard: shadow registers, tracking state and the queue of readings
    // still owed by the block
    // ------------------------------------------------------------------------
    class level_scoreboard;
        logic [PERIOD_W-1:0]       corr_period;
        logic [LIMIT_W-1:0]        loud_limit;
        logic [LIMIT_W-1:0]        quiet_limit;
        logic [THRESH_W-1:0]       loud_thr;
        logic [THRESH_W-1:0]       quiet_thr;
        logic [THRESH_W-1:0]       loud_clr;
        logic [THRESH_W-1:0]       quiet_clr;

        logic [SAMPLE_W-1:0]       prev_sample;
        logic signed [POS_W-1:0]   range_floor;
        logic signed [POS_W-1:0]   range_ceiling;
        logic [CORR_W-1:0]         corr_count;
        logic [NOISE_W-1:0]        loud_count;
        logic [NOISE_W-1:0]        quiet_count;

        meter_reading_t            owed_readings[$];
        int                        mismatches;
        int                        checked;
        int                        recentres;

        function new();
            corr_period   = CORR_PERIOD_RST;
            loud_limit    = LIMIT_RST;
            quiet_limit   = LIMIT_RST;
            loud_thr      = LOUD_THR_RST;
            quiet_thr     = QUIET_THR_RST;
            loud_clr      = LOUD_CLR_RST;
            quiet_clr     = QUIET_CLR_RST;
            prev_sample   = '0;
            range_floor   = '0;
            range_ceiling = '0;
            corr_count    = '0;
            loud_count    = '0;
            quiet_count   = '0;
            mismatches    = 0;
            checked       = 0;
            recentres     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CORR_PERIOD: corr_period = data[PERIOD_W-1:0];
                CFG_LOUD_LIMIT:  loud_limit  = data[LIMIT_W-1:0];
                CFG_QUIET_LIMIT: quiet_limit = data[LIMIT_W-1:0];
                CFG_LOUD_THR:    loud_thr    = data[THRESH_W-1:0];
                CFG_QUIET_THR:   quiet_thr   = data[THRESH_W-1:0];
                CFG_LOUD_CLR:    loud_clr    = data[THRESH_W-1:0];
                CFG_QUIET_CLR:   quiet_clr   = data[THRESH_W-1:0];
                default: ;
            endcase
        endfunction

        // value scaled against the midpoint and clamped to 0..full
        static function int scale_to(int value, int mid, int full);
            int q;
            if (mid == 0) begin
                return (value > 0) ? full : 0;
            end
            q = (value * full) / mid;
            if (q < 0) begin
                return 0;
            end
            return (q > full) ? full : q;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] smp);
            int s, fl, cl, half, span_v, mid, offset_mag, lvl, vol;
            meter_reading_t r;
            s           = int'(smp);
            fl          = range_floor;
            cl          = range_ceiling;
            r.recentred = 1'b0;

            corr_count = corr_count + 1'b1;
            if (corr_count > corr_period) begin
                fl++;
                cl--;
                corr_count = '0;
            end

            // floor lags one sample behind, ceiling follows the current one
            if (int'(prev_sample) < fl) begin
                fl = int'(prev_sample);
            end
            prev_sample = smp;
            if (s > cl) begin
                cl = s;
            end

            if (loud_count > loud_limit || quiet_count > quiet_limit) begin
                half        = s / 2;
                cl          = half + int'(CEIL_OFFSET);
                fl          = half - int'(FLOOR_OFFSET);
                loud_count  = '0;
                quiet_count = '0;
                r.recentred = 1'b1;
            end

            span_v     = cl - fl;
            mid        = span_v / 2;
            offset_mag = s - fl - mid;
            if (offset_mag < 0) begin
                offset_mag = -offset_mag;
            end
            lvl = scale_to(offset_mag, mid, int'(LEVEL_MAX));

            if (lvl > int'(loud_thr) && loud_count != NOISE_CNT_MAX) begin
                loud_count++;
            end
            if (lvl < int'(quiet_thr) && quiet_count != NOISE_CNT_MAX) begin
                quiet_count++;
            end
            if (lvl <= int'(loud_clr)) begin
                loud_count = '0;
            end
            if (lvl >= int'(quiet_clr)) begin
                quiet_count = '0;
            end

            vol = scale_to(lvl, mid, int'(VOLUME_MAX));

            range_floor   = POS_W'(fl);
            range_ceiling = POS_W'(cl);
            r.level       = LEVEL_W'(lvl);
            r.volume      = VOLUME_W'(vol);
            r.span        = POS_W'(span_v);
            owed_readings.push_back(r);
        endfunction

        function void report_mismatch(string what, int want, int got);
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what,
                         want, got);
            end
        endfunction

        function void check_result(logic [LEVEL_W-1:0] level, logic [VOLUME_W-1:0] volume,
                                   logic [POS_W-1:0] span, logic recentred);
            meter_reading_t e;
            if (owed_readings.size() == 0) begin
                report_mismatch("result with no sample outstanding, level", -1, int'(level));
                return;
            end
            e = owed_readings.pop_front();
            checked++;
            if (e.recentred) begin
                recentres++;
            end
            if (level !== e.level) begin
                report_mismatch("level", int'(e.level), int'(level));
            end
            if (volume !== e.volume) begin
                report_mismatch("volume", int'(e.volume), int'(volume));
            end
            if (span !== e.span) begin
                report_mismatch("span", int'($signed(e.span)), int'($signed(span)));
            end
            if (recentred !== e.recentred) begin
                report_mismatch("recentred", int'(e.recentred), int'(recentred));
            end
        endfunction

        function int pending();
            return owed_readings.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, block signals and bench state
    // ------------------------------------------------------------------------
    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [SAMPLE_W-1:0]           s_sample;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [LEVEL_W-1:0]            m_level;
    logic [VOLUME_W-1:0]           m_volume;
    logic signed [POS_W-1:0]       m_span;
    logic                          m_recentred;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;

    level_scoreboard sb = new();

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_req;          // bumped by the stimulus to request a hold-off
    int  hold_ack;          // owned by the receiver process
    int  hold_left;
    int  quiet_cycles;
    bit  timed_out;
    int  samples_sent;
    int  cfg_writes;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    auto_ranging_audio_level i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_level     (m_level),
        .m_volume    (m_volume),
        .m_span      (m_span),
        .m_recentred (m_recentred),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------------
    // monitor: every transaction is observed at the rising edge, before the
    // block's own registers move
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            // register shadow follows the write in the same edge
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
                cfg_writes++;
            end
            // a result always belongs to an older sample, so order here is free
            if (m_valid && m_ready) begin
                sb.check_result(m_level, m_volume, m_span, m_recentred);
            end
            if (s_valid && s_ready) begin
                sb.note_sample(s_sample);
                samples_sent++;
            end
        end
    end

    // watchdog: counts cycles in which nothing at all is transferred
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                timed_out <= 1'b1;
            end
        end
    end

    initial begin
        wait (timed_out);
        $display("watchdog: no transaction for %0d cycles, %0d results still owed",
                 WATCHDOG_LIMIT, sb.pending());
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request so the
    // block fills up and pushes back on its input
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // drivers: everything changes at the falling edge; each task returns at
    // the falling edge after its transaction so valid can stay high
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        // idle gaps before the transaction
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= value;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // random junk above the register width, which the block must drop
    function automatic logic [CFG_DATA_W-1:0] pad_upper(int value, int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom());
        return (junk << width) | CFG_DATA_W'(value);
    endfunction

    task automatic configure(int period, int loud_lim, int quiet_lim, int loud_t,
                             int quiet_t, int loud_c, int quiet_c);
        write_reg(CFG_NO_REG, CFG_DATA_W'($urandom()));
        write_reg(CFG_CORR_PERIOD, pad_upper(period, PERIOD_W));
        write_reg(CFG_LOUD_LIMIT, pad_upper(loud_lim, LIMIT_W));
        write_reg(CFG_QUIET_LIMIT, pad_upper(quiet_lim, LIMIT_W));
        write_reg(CFG_LOUD_THR, pad_upper(loud_t, THRESH_W));
        write_reg(CFG_QUIET_THR, pad_upper(quiet_t, THRESH_W));
        write_reg(CFG_LOUD_CLR, pad_upper(loud_c, THRESH_W));
        write_reg(CFG_QUIET_CLR, pad_upper(quiet_c, THRESH_W));
        cfg_valid <= 1'b0;
    endtask

    // one stretch of audio-like input: tones, silence, clipping bursts, slow
    // ramps and plain noise
    task automatic send_segment(int count);
        int kind, center, amp, stride, pos, dir, v;
        kind   = $urandom_range(0, 9);
        center = $urandom_range(0, SAMPLE_MAX);
        amp    = $urandom_range(0, 511);
        stride = $urandom_range(1, 64);
        dir    = $urandom_range(0, 1) ? 1 : -1;
        pos    = 0;
        for (int i = 0; i < count; i++) begin
            case (kind) inside
                0, 1, 2, 3: begin
                    // triangle tone around a random center
                    pos = pos + dir * stride;
                    if (pos > amp) begin
                        pos = amp;
                        dir = -1;
                    end
                    if (pos < -amp) begin
                        pos = -amp;
                        dir = 1;
                    end
                    v = center + pos;
                end
                4, 5: begin
                    // near silence, feeds the quiet counter
                    v = center + int'($urandom_range(0, 4)) - 2;
                end
                6: begin
                    // clipping between the rails, feeds the loud counter
                    v = (i % 2) ? SAMPLE_MAX - int'($urandom_range(0, 15))
                                : int'($urandom_range(0, 15));
                end
                7: begin
                    // slow ramp, lets floor overtake ceiling by one
                    v = center + dir * i;
                end
                default: begin
                    v = $urandom_range(0, SAMPLE_MAX);
                end
            endcase
            if (v < 0) begin
                v = 0;
            end
            if (v > SAMPLE_MAX) begin
                v = SAMPLE_MAX;
            end
            send_sample(SAMPLE_W'(v));
        end
    endtask

    task automatic run_phase(int items);
        int sent, len;
        sent = 0;
        while (sent < items) begin
            len = $urandom_range(4, 60);
            if (len > items - sent) begin
                len = items - sent;
            end
            send_segment(len);
            sent += len;
        end
        s_valid <= 1'b0;
    endtask

    // registers may only change once every owed reading is back
    task automatic wait_drained();
        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    int idle_table[4]  = '{0, 52, 0, 13};
    int stall_table[4] = '{0, 0, 52, 13};

    // first sample with period 0 gives a zero midpoint with a nonzero offset;
    // the flat run then the one-step descent makes the floor pass the ceiling
    // by one; the rest hits both rails and the middle
    int directed_samples[15] = '{1, 3, 3, 3, 3, 2, 1, 0, 0, 1023, 0, 1023, 512, 511, 1023};

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_sample       = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        hold_ack       = 0;
        hold_left      = 0;
        quiet_cycles   = 0;
        timed_out      = 1'b0;
        samples_sent   = 0;
        cfg_writes     = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part: period 0 written with junk above bit 14, the other
        // registers stay at their reset values
        write_reg(CFG_NO_REG, CFG_DATA_W'(0));
        write_reg(CFG_CORR_PERIOD, CFG_DATA_W'(1 << PERIOD_W));
        cfg_valid <= 1'b0;
        foreach (directed_samples[i]) begin
            send_sample(SAMPLE_W'(directed_samples[i]));
        end
        s_valid <= 1'b0;
        wait_drained();

        // random part: one register setting and one idling pattern per phase
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: configure(0, 0, 0, 0, 511, 0, 511);
                1: configure(32767, 1048575, 1048575, 511, 0, 511, 0);
                2: configure(1000, 10000, 10000, 384, 128, 0, 511);
                3: configure(5, 20, 30, 384, 128, 0, 511);
                default: begin
                    configure($urandom_range(0, 40), $urandom_range(0, 120),
                              $urandom_range(0, 120), $urandom_range(0, 511),
                              $urandom_range(0, 511), $urandom_range(0, 80),
                              $urandom_range(400, 511));
                end
            endcase
            send_idle_pct  <= idle_table[ph % 4];
            recv_stall_pct <= stall_table[ph % 4];
            if (ph == PRESSURE_PHASE) begin
                hold_req <= hold_req + 1;
            end
            run_phase(ITEMS_PER_PHASE);
            wait_drained();
        end

        $display("%0d samples over %0d register writes and %0d phases of handshake idling",
                 samples_sent, cfg_writes, PHASES);
        $display("%0d readings checked, %0d of them re-centered, %0d mismatches",
                 sb.checked, sb.recentres, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### auto_ranging_audio_level.f
hw/rtl/arl_pkg.sv
hw/rtl/arl_div.sv
hw/rtl/arl_ctrl.sv
hw/rtl/arl_datapath.sv
hw/rtl/auto_ranging_audio_level.sv
verif/auto_ranging_audio_level_test.sv
